// ===== rtl/lc3_instruction_executor_assert.svh =====
// ----------------------------------------------------------------------------
// LC-3 executor assertion macros
// Implication checks on the core's own control signals; empty when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef LC3_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define LC3_INSTRUCTION_EXECUTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define LC3_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("LC-3 executor check failed (same cycle)");
`define LC3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("LC-3 executor check failed (next cycle)");
`else
`define LC3_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LC3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lc3ie_pkg.sv =====
// ----------------------------------------------------------------------------
// lc3ie_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package lc3ie_pkg;

    localparam int ADDR_BITS_DEF  = 16;
    localparam int MAX_STRING_DEF = 64;
    localparam logic [15:0] ORIGIN_RESET = 16'h3000;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_JUMP = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    // Result kinds carried in the output tuser.
    localparam logic [2:0] KIND_EXEC   = 3'd0;
    localparam logic [2:0] KIND_HALTED = 3'd1;
    localparam logic [2:0] KIND_LOAD   = 3'd2;
    localparam logic [2:0] KIND_JUMP   = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;
    localparam logic [2:0] KIND_CHAR   = 3'd5;

    // Opcodes.
    localparam logic [3:0] OPC_BR   = 4'd0;
    localparam logic [3:0] OPC_ADD  = 4'd1;
    localparam logic [3:0] OPC_LD   = 4'd2;
    localparam logic [3:0] OPC_ST   = 4'd3;
    localparam logic [3:0] OPC_JSR  = 4'd4;
    localparam logic [3:0] OPC_AND  = 4'd5;
    localparam logic [3:0] OPC_LDR  = 4'd6;
    localparam logic [3:0] OPC_STR  = 4'd7;
    localparam logic [3:0] OPC_NOT  = 4'd9;
    localparam logic [3:0] OPC_LDI  = 4'd10;
    localparam logic [3:0] OPC_STI  = 4'd11;
    localparam logic [3:0] OPC_JMP  = 4'd12;
    localparam logic [3:0] OPC_LEA  = 4'd14;
    localparam logic [3:0] OPC_TRAP = 4'd15;

    // Trap vectors.
    localparam logic [7:0] TRAP_GETC = 8'h20;
    localparam logic [7:0] TRAP_OUT  = 8'h21;
    localparam logic [7:0] TRAP_PUTS = 8'h22;
    localparam logic [7:0] TRAP_IN   = 8'h23;

    // Condition codes.
    localparam logic [2:0] CC_N = 3'd4;
    localparam logic [2:0] CC_Z = 3'd2;
    localparam logic [2:0] CC_P = 3'd1;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_LATCH,
        OP_LOAD,
        OP_JUMP,
        OP_READ,
        OP_FETCH,
        OP_DECODE_IR,
        OP_EXEC,
        OP_LOAD_WB,
        OP_INDIRECT,
        OP_STR_RD,
        OP_EMIT_OUT,
        OP_EMIT_STR,
        OP_EMIT_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [2:0] kind;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       run;
        logic [3:0] opcode;
        logic       trap_out;
        logic       trap_puts;
        logic       clr_done;
        logic       str_end;
        logic       str_full;
        logic       slot_free;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_DECODE,
        S_EXEC,
        S_LOAD_WB,
        S_INDIRECT,
        S_OUT,
        S_STR_RD,
        S_STR_CHK,
        S_RESULT
    } t_ctrl_state;

endpackage

`default_nettype wire

// ===== rtl/lc3ie_ctrl.sv =====
// ----------------------------------------------------------------------------
// lc3ie_ctrl
// Sequencer: memory clear, command dispatch and the instruction phases.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3ie_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire lc3ie_pkg::t_dp_stat i_stat,
    output lc3ie_pkg::t_dp_cmd       o_cmd
);
    import lc3ie_pkg::*;

    t_ctrl_state r_state, n_state;
    logic [2:0]  r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_kind  <= KIND_EXEC;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_s_tready = 1'b0;
        o_cmd.op   = OP_IDLE;
        o_cmd.kind = r_kind;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_RESULT;
                case (i_stat.cmd)
                    CMD_LOAD: begin
                        o_cmd.op = OP_LOAD;
                        n_kind   = KIND_LOAD;
                    end
                    CMD_JUMP: begin
                        o_cmd.op = OP_JUMP;
                        n_kind   = KIND_JUMP;
                    end
                    CMD_READ: begin
                        o_cmd.op = OP_READ;
                        n_kind   = KIND_READ;
                    end
                    default: begin
                        if (i_stat.run) begin
                            o_cmd.op = OP_FETCH;
                            n_kind   = KIND_EXEC;
                            n_state  = S_DECODE;
                        end else begin
                            n_kind = KIND_HALTED;
                        end
                    end
                endcase
            end
            S_DECODE: begin
                o_cmd.op = OP_DECODE_IR;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.op = OP_EXEC;
                n_state  = S_RESULT;
                case (i_stat.opcode)
                    OPC_LD, OPC_LDR: n_state = S_LOAD_WB;
                    OPC_LDI, OPC_STI: n_state = S_INDIRECT;
                    OPC_TRAP: begin
                        if (i_stat.trap_out) begin
                            n_state = S_OUT;
                        end else if (i_stat.trap_puts) begin
                            n_state = S_STR_RD;
                        end
                    end
                    default: n_state = S_RESULT;
                endcase
            end
            S_LOAD_WB: begin
                o_cmd.op = OP_LOAD_WB;
                n_state  = S_RESULT;
            end
            S_INDIRECT: begin
                o_cmd.op = OP_INDIRECT;
                n_state  = (i_stat.opcode == OPC_LDI) ? S_LOAD_WB : S_RESULT;
            end
            S_OUT: begin
                if (i_stat.slot_free) begin
                    o_cmd.op = OP_EMIT_OUT;
                    n_state  = S_RESULT;
                end
            end
            S_STR_RD: begin
                if (i_stat.str_full) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.op = OP_STR_RD;
                    n_state  = S_STR_CHK;
                end
            end
            S_STR_CHK: begin
                if (i_stat.str_end) begin
                    n_state = S_RESULT;
                end else if (i_stat.slot_free) begin
                    o_cmd.op = OP_EMIT_STR;
                    n_state  = S_STR_RD;
                end
            end
            S_RESULT: begin
                if (i_stat.slot_free) begin
                    o_cmd.op = OP_EMIT_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lc3ie_dp.sv =====
// ----------------------------------------------------------------------------
// lc3ie_dp
// Datapath: word memory, register file, PC, condition code and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3ie_dp #(
    parameter int ADDR_BITS  = lc3ie_pkg::ADDR_BITS_DEF,
    parameter int MAX_STRING = lc3ie_pkg::MAX_STRING_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata,
    input  wire logic [1:0]         i_s_tuser,
    input  wire logic [39:0]        i_s_tdata,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [79:0]             o_m_tdata,
    output logic [2:0]              o_m_tuser,
    output logic                    o_m_tlast,
    input  wire lc3ie_pkg::t_dp_cmd i_cmd,
    output lc3ie_pkg::t_dp_stat     o_stat
);
    import lc3ie_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;
    localparam int CNT_W = $clog2(MAX_STRING + 1);

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        if (v == 16'd0) begin
            return CC_Z;
        end else if (v[15]) begin
            return CC_N;
        end
        return CC_P;
    endfunction

    logic [15:0]          r_mem [DEPTH];
    logic [15:0]          r_rdata;
    logic [ADDR_BITS-1:0] r_clr;
    logic [15:0]          r_gpr [8];
    logic [15:0]          r_pc, r_ia, r_ir, r_ptr;
    logic [2:0]           r_cc;
    logic                 r_run;
    logic [CNT_W-1:0]     r_cnt;
    logic [1:0]           r_cmd;
    logic [15:0]          r_addr, r_data;
    logic [7:0]           r_char;

    logic                 r_out_valid, r_out_last;
    logic [2:0]           r_out_kind;
    logic [15:0]          r_out_ia, r_out_ir, r_out_pc, r_out_rd;
    logic [2:0]           r_out_cc;
    logic                 r_out_run;
    logic [7:0]           r_out_ch;

    logic [3:0]  opcode;
    logic [2:0]  dr, sr;
    logic [15:0] pc_off9, base_off6, alu_b, sum, conj, jsr_tgt;
    logic        slot_free, emit;
    logic        mem_we, mem_re;
    logic [15:0] mem_wa, mem_ra, mem_wd;

    assign opcode    = r_ir[15:12];
    assign dr        = r_ir[11:9];
    assign sr        = r_ir[8:6];
    assign pc_off9   = r_pc + {{7{r_ir[8]}}, r_ir[8:0]};
    assign base_off6 = r_gpr[sr] + {{10{r_ir[5]}}, r_ir[5:0]};
    assign alu_b     = r_ir[5] ? {{11{r_ir[4]}}, r_ir[4:0]} : r_gpr[r_ir[2:0]];
    assign sum       = r_gpr[sr] + alu_b;
    assign conj      = r_gpr[sr] & alu_b;
    assign jsr_tgt   = r_ir[11] ? (r_pc + {{5{r_ir[10]}}, r_ir[10:0]}) : r_gpr[sr];
    assign slot_free = !r_out_valid || i_m_tready;
    assign emit      = (i_cmd.op == OP_EMIT_OUT) || (i_cmd.op == OP_EMIT_STR)
                    || (i_cmd.op == OP_EMIT_RESULT);

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.run       = r_run;
        o_stat.opcode    = opcode;
        o_stat.trap_out  = (r_ir[7:0] == TRAP_OUT);
        o_stat.trap_puts = (r_ir[7:0] == TRAP_PUTS);
        o_stat.clr_done  = &r_clr;
        o_stat.str_end   = (r_rdata[7:0] == 8'd0);
        o_stat.str_full  = (r_cnt == CNT_W'(MAX_STRING - 1));
        o_stat.slot_free = slot_free;
    end

    // Memory port selection.
    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = r_addr;
        mem_ra = r_addr;
        mem_wd = r_gpr[dr];
        case (i_cmd.op)
            OP_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = 16'(r_clr);
                mem_wd = 16'd0;
            end
            OP_LOAD: begin
                mem_we = 1'b1;
                mem_wd = r_data;
            end
            OP_READ: mem_re = 1'b1;
            OP_FETCH: begin
                mem_re = 1'b1;
                mem_ra = r_pc;
            end
            OP_EXEC: begin
                case (opcode)
                    OPC_LD, OPC_LDI, OPC_STI: begin
                        mem_re = 1'b1;
                        mem_ra = pc_off9;
                    end
                    OPC_LDR: begin
                        mem_re = 1'b1;
                        mem_ra = base_off6;
                    end
                    OPC_ST: begin
                        mem_we = 1'b1;
                        mem_wa = pc_off9;
                    end
                    OPC_STR: begin
                        mem_we = 1'b1;
                        mem_wa = base_off6;
                    end
                    default: mem_re = 1'b0;
                endcase
            end
            OP_INDIRECT: begin
                mem_ra = r_rdata;
                mem_wa = r_rdata;
                if (opcode == OPC_LDI) begin
                    mem_re = 1'b1;
                end else begin
                    mem_we = 1'b1;
                end
            end
            OP_STR_RD: begin
                mem_re = 1'b1;
                mem_ra = r_ptr;
            end
            default: mem_re = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa[ADDR_BITS-1:0]] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra[ADDR_BITS-1:0]];
        end
    end

    // Architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_pc  <= ORIGIN_RESET;
            r_cc  <= CC_Z;
            r_run <= 1'b1;
            r_cnt <= '0;
            r_cmd <= CMD_LOAD;
            for (int k = 0; k < 8; k++) begin
                r_gpr[k] <= 16'd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end
            case (i_cmd.op)
                OP_CLEAR: r_clr <= r_clr + 1'b1;
                OP_LATCH: begin
                    r_cmd  <= i_s_tuser;
                    r_addr <= i_s_tdata[15:0];
                    r_data <= i_s_tdata[31:16];
                    r_char <= i_s_tdata[39:32];
                end
                OP_JUMP: begin
                    r_pc  <= r_addr;
                    r_run <= 1'b1;
                end
                OP_FETCH: r_ia <= r_pc;
                OP_DECODE_IR: begin
                    r_ir <= r_rdata;
                    r_pc <= r_pc + 16'd1;
                end
                OP_EXEC: begin
                    case (opcode)
                        OPC_BR: begin
                            if (|(dr & r_cc)) begin
                                r_pc <= pc_off9;
                            end
                        end
                        OPC_ADD: begin
                            r_gpr[dr] <= sum;
                            r_cc      <= cc_of(sum);
                        end
                        OPC_AND: begin
                            r_gpr[dr] <= conj;
                            r_cc      <= cc_of(conj);
                        end
                        OPC_NOT: begin
                            r_gpr[dr] <= ~r_gpr[sr];
                            r_cc      <= cc_of(~r_gpr[sr]);
                        end
                        OPC_LEA: begin
                            r_gpr[dr] <= pc_off9;
                            r_cc      <= cc_of(pc_off9);
                        end
                        OPC_JMP: r_pc <= r_gpr[sr];
                        OPC_JSR: begin
                            r_gpr[7] <= r_pc;
                            r_pc     <= jsr_tgt;
                        end
                        OPC_TRAP: begin
                            r_gpr[7] <= r_pc;
                            // A known service routine entered from the upper half reads
                            // as negative; HALT and unknown vectors force positive below.
                            if (r_pc[15] && (r_ir[7:0] inside
                                    {TRAP_GETC, TRAP_OUT, TRAP_PUTS, TRAP_IN})) begin
                                r_cc <= CC_N;
                            end
                            case (r_ir[7:0])
                                TRAP_GETC, TRAP_IN: r_gpr[0] <= {{8{r_char[7]}}, r_char};
                                TRAP_OUT: r_ptr <= r_gpr[0];
                                TRAP_PUTS: begin
                                    r_ptr <= r_gpr[0];
                                    r_cnt <= '0;
                                end
                                default: begin
                                    r_cc  <= CC_P;
                                    r_run <= 1'b0;
                                end
                            endcase
                        end
                        default: r_cc <= r_cc;
                    endcase
                end
                OP_LOAD_WB: begin
                    r_gpr[dr] <= r_rdata;
                    r_cc      <= cc_of(r_rdata);
                end
                OP_EMIT_STR: begin
                    r_ptr <= r_ptr + 16'd1;
                    r_cnt <= r_cnt + 1'b1;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_pc  <= r_pc;
            r_out_cc  <= r_cc;
            r_out_run <= r_run;
            case (i_cmd.op)
                OP_EMIT_OUT: begin
                    r_out_kind <= KIND_CHAR;
                    r_out_last <= 1'b0;
                    r_out_ch   <= r_ptr[7:0];
                    r_out_ia   <= r_ia;
                    r_out_ir   <= r_ir;
                    r_out_rd   <= 16'd0;
                end
                OP_EMIT_STR: begin
                    r_out_kind <= KIND_CHAR;
                    r_out_last <= 1'b0;
                    r_out_ch   <= r_rdata[7:0];
                    r_out_ia   <= r_ia;
                    r_out_ir   <= r_ir;
                    r_out_rd   <= 16'd0;
                end
                default: begin
                    r_out_kind <= i_cmd.kind;
                    r_out_last <= 1'b1;
                    r_out_ch   <= 8'd0;
                    r_out_ia   <= (i_cmd.kind == KIND_EXEC) ? r_ia : 16'd0;
                    r_out_ir   <= (i_cmd.kind == KIND_EXEC) ? r_ir : 16'd0;
                    r_out_rd   <= (i_cmd.kind == KIND_READ) ? r_rdata : 16'd0;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {4'd0, r_out_rd, r_out_ch, r_out_run, r_out_cc,
                         r_out_pc, r_out_ir, r_out_ia};

endmodule

`default_nettype wire

// ===== rtl/lc3_instruction_executor.sv =====
// LC-3 style instruction executor: one command word in, one or more result words out.
// Throughput: one word at a time; the next word is taken once the final result is registered.
// Reset (synchronous, active low) starts a clearing pass that zeroes all 2^ADDR_BITS words of
// the memory; input is held off until it ends, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// lc3_instruction_executor
// Top level: controller and datapath of a small sixteen-bit LC-3 style core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lc3_instruction_executor_assert.svh"

module lc3_instruction_executor #(
    parameter int ADDR_BITS  = lc3ie_pkg::ADDR_BITS_DEF,
    parameter int MAX_STRING = lc3ie_pkg::MAX_STRING_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // A configuration write loads the program counter directly; reset restores 16'h3000.
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: address [15:0], data [31:16], in_char [39:32]
    input  wire logic [39:0] s_tdata,
    // tuser: cmd [1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: instr_addr [15:0], instr [31:16], next_pc [47:32], cond [50:48],
    //        running [51], char_out [59:52], read_data [75:60], zero fill above
    output logic [79:0]      m_tdata,
    // tuser: kind [2:0]
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);
    import lc3ie_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The controller sequences each word through its phases; the datapath owns
    // the memory, the architectural state and the output register, so a finished
    // result can wait there while the next word is taken in.
    lc3ie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lc3ie_dp #(
        .ADDR_BITS  (ADDR_BITS),
        .MAX_STRING (MAX_STRING)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tuser   (s_tuser),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    // No word is taken while the memory is still being cleared.
    `LC3_ASSERT_SAME(a_no_accept_in_clear, i_clk, i_rst_n, cmd.op == OP_CLEAR, !s_tready)
    // A result is only loaded when the output register is free.
    `LC3_ASSERT_SAME(a_emit_slot_free, i_clk, i_rst_n,
        cmd.op == OP_EMIT_RESULT || cmd.op == OP_EMIT_STR || cmd.op == OP_EMIT_OUT,
        stat.slot_free)
    // After a word is accepted the core is busy in the next cycle.
    `LC3_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire
